[design/dgr_pkg.sv]
// ---------------------------------------------------------------------------
// dgr_pkg
// Shared widths, pipeline depths, codes and constant tables of the distance
// gain roll-off core.
// ---------------------------------------------------------------------------
package dgr_pkg;

   localparam int DATA_W     = 16;                    // field width
   localparam int FRAC_W     = 12;                    // fraction bits of fields
   localparam int LOG_W      = 24;                    // fraction bits of log2
   localparam int W_W        = 63;                    // weight width into affine
   localparam int Q_W        = 30;                    // cosine angle fraction bits
   localparam int DIV_STEPS  = 3;                     // quotient bits per stage
   localparam int DIV_STAGES = Q_W / DIV_STEPS;
   localparam int PWR_LAT    = 2 * LOG_W + 3;         // normalize, log, mult, exp, shift
   localparam int AFF_LAT    = 3;
   localparam int COS_LAT    = DIV_STAGES + 9;
   localparam int CORE_LAT   = PWR_LAT + AFF_LAT;
   localparam int COS_PAD    = CORE_LAT - COS_LAT;

   localparam logic [W_W-1:0] BIG_W  = W_W'(1) << 62;
   localparam logic [W_W-1:0] ONE_W  = W_W'(1) << FRAC_W;
   localparam logic [31:0]    ACC_ONE = 32'h4000_0000;

   // cosine polynomial in v = u^2, Q2.30, Horner order
   localparam logic signed [31:0] COS_A5 = 32'sd27061;
   localparam logic signed [31:0] COS_K [0:4] = '{
      32'sd987048, 32'sd22401991, 32'sd272375560, 32'sd1324675879, 32'sd1073741824
   };

   typedef enum logic [1:0] {
      MODE_ZERO,
      MODE_LIN,
      MODE_POW,
      MODE_COS
   } mode_type;

   typedef enum logic [2:0] {
      CSR_MODE,
      CSR_LIN_OFFSET,
      CSR_LIN_SLOPE,
      CSR_POW_OFFSET,
      CSR_POW_SLOPE,
      CSR_POW_EXPONENT,
      CSR_COS_GAIN,
      CSR_COS_WIDTH
   } csr_index_type;

   // floor square root, used only on constants
   function automatic logic [63:0] isqrt64(input logic [63:0] n);
      logic [63:0] rem;
      logic [63:0] res;
      logic [63:0] bit_v;
      rem   = n;
      res   = '0;
      bit_v = 64'd1 << 62;
      for (int i = 0; i < 32; i++) begin
         if (bit_v > rem) bit_v = bit_v >> 2;
      end
      for (int i = 0; i < 32; i++) begin
         if (bit_v != 64'd0) begin
            if (rem >= res + bit_v) begin
               rem = rem - (res + bit_v);
               res = (res >> 1) + bit_v;
            end else begin
               res = res >> 1;
            end
            bit_v = bit_v >> 2;
         end
      end
      return res;
   endfunction

   // 2^(2^-k) in Q2.30, each root taken from the previous one
   function automatic logic [31:0] exp_root(input int k);
      logic [63:0] r;
      r = 64'd1 << 31;
      for (int j = 1; j <= k; j++) begin
         r = isqrt64(r << 30);
      end
      return r[31:0];
   endfunction

endpackage

[design/dgr_power.sv]
// ---------------------------------------------------------------------------
// dgr_power
// Pipelined distance^exponent: normalize, 24 squaring stages for log2,
// product with the exponent, 24 root-multiply stages for 2^z, final shift.
// ---------------------------------------------------------------------------
module dgr_power (
   input  logic                        clock,
   input  logic                        adv,
   input  logic [dgr_pkg::DATA_W-1:0]  in_d,
   input  logic [dgr_pkg::DATA_W-1:0]  exponent,
   input  logic                        sel_lin,
   output logic [dgr_pkg::W_W-1:0]     out_w
);
   import dgr_pkg::*;

   logic [3:0]        lod_p;
   logic [31:0]       lod_m;
   logic [31:0]       sq_m_ff  [0:LOG_W];
   logic [LOG_W-1:0]  frac_ff  [0:LOG_W];
   logic [3:0]        p_ff     [0:LOG_W];
   logic [DATA_W-1:0] dl_ff    [0:PWR_LAT-2];
   logic signed [28:0] log_v;
   logic signed [45:0] prod_ff;
   logic [31:0]       acc_ff   [1:LOG_W];
   logic [LOG_W-1:0]  zf_ff    [1:LOG_W];
   logic [9:0]        zi_ff    [1:LOG_W];
   logic signed [10:0] sh_s;
   logic [10:0]       neg_s;
   logic [40:0]       rnd;
   logic [W_W-1:0]    pw;
   logic [W_W-1:0]    w_in;
   logic [W_W-1:0]    w_ff;

   // leading one and normalized mantissa
   always_comb begin
      lod_p = '0;
      for (int i = 0; i < DATA_W; i++) begin
         if (in_d[i]) lod_p = 4'(i);
      end
      lod_m = {16'b0, in_d} << (5'd31 - {1'b0, lod_p});
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         sq_m_ff[0] <= lod_m;
         p_ff[0]    <= lod_p;
         frac_ff[0] <= '0;
         dl_ff[0]   <= in_d;
         for (int i = 1; i <= PWR_LAT - 2; i++) begin
            dl_ff[i] <= dl_ff[i-1];
         end
      end
   end

   // one log2 fraction bit per stage
   for (genvar k = 1; k <= LOG_W; k++) begin : g_log
      logic [63:0] sq;
      logic [32:0] sh;
      assign sq = 64'(sq_m_ff[k-1]) * 64'(sq_m_ff[k-1]);
      assign sh = sq[63:31];
      always_ff @(posedge clock) begin
         if (adv) begin
            sq_m_ff[k] <= sh[32] ? sh[32:1] : sh[31:0];
            frac_ff[k] <= {frac_ff[k-1][LOG_W-2:0], sh[32]};
            p_ff[k]    <= p_ff[k-1];
         end
      end
   end

   assign log_v = {5'({1'b0, p_ff[LOG_W]} - 5'(FRAC_W)), frac_ff[LOG_W]};

   always_ff @(posedge clock) begin
      if (adv) begin
         prod_ff <= log_v * $signed({1'b0, exponent});
      end
   end

   // 2^z: multiply by one constant root per fraction bit of z
   for (genvar k = 1; k <= LOG_W; k++) begin : g_exp
      localparam logic [31:0] ROOT = exp_root(k);
      logic [31:0]      acc_p;
      logic [LOG_W-1:0] zf_p;
      logic [9:0]       zi_p;
      logic [63:0]      mul;
      if (k == 1) begin : g_first
         assign acc_p = ACC_ONE;
         assign zf_p  = prod_ff[FRAC_W+LOG_W-1:FRAC_W];
         assign zi_p  = prod_ff[45:FRAC_W+LOG_W];
      end else begin : g_next
         assign acc_p = acc_ff[k-1];
         assign zf_p  = zf_ff[k-1];
         assign zi_p  = zi_ff[k-1];
      end
      assign mul = 64'(acc_p) * 64'(ROOT);
      always_ff @(posedge clock) begin
         if (adv) begin
            acc_ff[k] <= zf_p[LOG_W-k] ? mul[61:30] : acc_p;
            zf_ff[k]  <= zf_p;
            zi_ff[k]  <= zi_p;
         end
      end
   end

   // align Q2.30 to Q.12 by the integer part of z
   always_comb begin
      sh_s  = $signed({zi_ff[LOG_W][9], zi_ff[LOG_W]}) - 11'sd18;
      neg_s = 11'(-sh_s);
      rnd   = 41'(acc_ff[LOG_W]) + (41'd1 << (neg_s[5:0] - 6'd1));
      if (sh_s > 11'sd31) begin
         pw = BIG_W;
      end else if (!sh_s[10]) begin
         pw = W_W'(acc_ff[LOG_W]) << sh_s[4:0];
      end else if (neg_s > 11'd40) begin
         pw = '0;
      end else begin
         pw = W_W'(rnd >> neg_s[5:0]);
      end
      if (sel_lin) begin
         w_in = W_W'(dl_ff[PWR_LAT-2]);
      end else if (exponent == '0) begin
         w_in = ONE_W;
      end else if (dl_ff[PWR_LAT-2] == '0) begin
         w_in = '0;
      end else begin
         w_in = pw;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         w_ff <= w_in;
      end
   end

   assign out_w = w_ff;

endmodule

[design/dgr_affine.sv]
// ---------------------------------------------------------------------------
// dgr_affine
// offset - slope * w with overflow saturation, rounding and output clamp,
// in three stages: partial products, sum and range check, round and clamp.
// ---------------------------------------------------------------------------
module dgr_affine (
   input  logic                              clock,
   input  logic                              adv,
   input  logic [dgr_pkg::W_W-1:0]           w,
   input  logic signed [dgr_pkg::DATA_W-1:0] offset,
   input  logic signed [dgr_pkg::DATA_W-1:0] slope,
   output logic [dgr_pkg::DATA_W-1:0]        gain
);
   import dgr_pkg::*;

   logic [16:0]        sext;
   logic [16:0]        mag;
   logic [47:0]        pl_ff;
   logic [48:0]        ph_ff;
   logic               neg1_ff;
   logic [79:0]        full;
   logic               big_ff;
   logic               neg2_ff;
   logic [W_W-1:0]     mw_ff;
   logic signed [65:0] mwx;
   logic signed [65:0] prd;
   logic signed [65:0] num;
   logic [DATA_W-1:0]  gain_in;
   logic [DATA_W-1:0]  gain_ff;

   assign sext = {slope[DATA_W-1], slope};
   assign mag  = slope[DATA_W-1] ? 17'(-sext) : sext;
   assign full = {ph_ff, 31'b0} + 80'(pl_ff);

   always_ff @(posedge clock) begin
      if (adv) begin
         pl_ff   <= 48'(mag) * 48'(w[30:0]);
         ph_ff   <= 49'(mag) * 49'(w[62:31]);
         neg1_ff <= slope[DATA_W-1];
         big_ff  <= full > (80'd1 << 62);
         mw_ff   <= full[W_W-1:0];
         neg2_ff <= neg1_ff;
         gain_ff <= gain_in;
      end
   end

   always_comb begin
      mwx = {3'b0, mw_ff};
      prd = neg2_ff ? -mwx : mwx;
      num = {{38{offset[DATA_W-1]}}, offset, 12'b0} - prd + 66'sd2048;
      if (big_ff) begin
         gain_in = neg2_ff ? '1 : '0;
      end else if (num[65]) begin
         gain_in = '0;
      end else if (|num[64:28]) begin
         gain_in = '1;
      end else begin
         gain_in = num[27:12];
      end
   end

   assign gain = gain_ff;

endmodule

[design/dgr_cosine.sv]
// ---------------------------------------------------------------------------
// dgr_cosine
// Cosine roll-off: pipelined divide for the angle, square, five Horner
// stages, peak gain multiply, round and clamp.
// ---------------------------------------------------------------------------
module dgr_cosine (
   input  logic                              clock,
   input  logic                              adv,
   input  logic [dgr_pkg::DATA_W-1:0]        in_d,
   input  logic signed [dgr_pkg::DATA_W-1:0] cgain,
   input  logic [dgr_pkg::DATA_W-1:0]        cwidth,
   output logic [dgr_pkg::DATA_W-1:0]        gain
);
   import dgr_pkg::*;

   logic [DATA_W-1:0]  wf;
   logic [DATA_W-1:0]  rem_ff [0:DIV_STAGES];
   logic [Q_W-1:0]     q_ff   [0:DIV_STAGES];
   logic               ge_ff  [0:DIV_STAGES];
   logic [Q_W:0]       u;
   logic [61:0]        uu;
   logic [Q_W:0]       v_ff;
   logic signed [31:0] t_ff  [0:4];
   logic [Q_W:0]       vh_ff [0:4];
   logic [Q_W:0]       cpos;
   logic signed [47:0] gp_ff;
   logic signed [47:0] rs;
   logic [DATA_W-1:0]  gain_in;
   logic [DATA_W-1:0]  gain_ff;

   assign wf = (cwidth == '0) ? DATA_W'(1) : cwidth;

   always_ff @(posedge clock) begin
      if (adv) begin
         rem_ff[0] <= in_d;
         q_ff[0]   <= '0;
         ge_ff[0]  <= in_d >= wf;
      end
   end

   // restoring divide of d * 2^30 by width, a few quotient bits per stage
   for (genvar j = 1; j <= DIV_STAGES; j++) begin : g_div
      logic [DATA_W-1:0]    r;
      logic [DATA_W:0]      r2;
      logic [DIV_STEPS-1:0] qb;
      always_comb begin
         r  = rem_ff[j-1];
         r2 = '0;
         qb = '0;
         for (int s = 0; s < DIV_STEPS; s++) begin
            r2 = {r, 1'b0};
            if (r2 >= {1'b0, wf}) begin
               r2 = r2 - {1'b0, wf};
               qb[DIV_STEPS-1-s] = 1'b1;
            end
            r = r2[DATA_W-1:0];
         end
      end
      always_ff @(posedge clock) begin
         if (adv) begin
            rem_ff[j] <= r;
            q_ff[j]   <= {q_ff[j-1][Q_W-DIV_STEPS-1:0], qb};
            ge_ff[j]  <= ge_ff[j-1];
         end
      end
   end

   // clamp angle at a quarter turn
   assign u  = ge_ff[DIV_STAGES] ? (31'd1 << Q_W) : {1'b0, q_ff[DIV_STAGES]};
   assign uu = 62'(u) * 62'(u);

   always_ff @(posedge clock) begin
      if (adv) begin
         v_ff <= uu[60:30];
      end
   end

   for (genvar h = 0; h < 5; h++) begin : g_horner
      logic signed [31:0] tp;
      logic [Q_W:0]       vp;
      logic signed [63:0] mt;
      if (h == 0) begin : g_first
         assign tp = COS_A5;
         assign vp = v_ff;
      end else begin : g_next
         assign tp = t_ff[h-1];
         assign vp = vh_ff[h-1];
      end
      assign mt = $signed({1'b0, vp}) * tp;
      always_ff @(posedge clock) begin
         if (adv) begin
            t_ff[h]  <= COS_K[h] - 32'(mt >>> 30);
            vh_ff[h] <= vp;
         end
      end
   end

   // drop negative cosine
   assign cpos = t_ff[4][31] ? '0 : t_ff[4][Q_W:0];
   assign rs   = gp_ff + 48'sd536870912;

   always_comb begin
      if (rs[47]) begin
         gain_in = '0;
      end else if (rs[46]) begin
         gain_in = '1;
      end else begin
         gain_in = rs[45:30];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         gp_ff   <= cgain * $signed({1'b0, cpos});
         gain_ff <= gain_in;
      end
   end

   assign gain = gain_ff;

endmodule

[design/distance_gain_rolloff_core.sv]
// ---------------------------------------------------------------------------
// distance_gain_rolloff_core
// Distance to panning gain per mode register: zero, linear, power or cosine.
// ---------------------------------------------------------------------------
// Fully pipelined: one distance item enters per cycle unless the result item
// is held. The depth comes from the power curve: a normalize register, 24
// squaring stages for log2, one exponent product stage, 24 constant-root
// multiply stages for 2^z, a shift register and 3 affine stages. The cosine
// path is shorter and is delayed to the same depth. When the result item is
// not taken the whole pipeline holds, so ready follows the output side.
// Registers may be written only while no item is in flight.
module distance_gain_rolloff_core (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [dgr_pkg::DATA_W-1:0]  req_distance,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [dgr_pkg::DATA_W-1:0]  rsp_gain,
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [2:0]                  csr_index,
   input  logic [dgr_pkg::DATA_W-1:0]  csr_data
);
   import dgr_pkg::*;

   mode_type           mode_ff;
   logic signed [DATA_W-1:0] lin_offset_ff;
   logic signed [DATA_W-1:0] lin_slope_ff;
   logic signed [DATA_W-1:0] pow_offset_ff;
   logic signed [DATA_W-1:0] pow_slope_ff;
   logic [DATA_W-1:0]  pow_exponent_ff;
   logic signed [DATA_W-1:0] cos_gain_ff;
   logic [DATA_W-1:0]  cos_width_ff;

   logic                adv;
   logic [CORE_LAT-1:0] vld_ff;
   logic                sel_lin;
   logic [W_W-1:0]      pwr_w;
   logic signed [DATA_W-1:0] aff_off;
   logic signed [DATA_W-1:0] aff_slope;
   logic [DATA_W-1:0]   aff_gain;
   logic [DATA_W-1:0]   cos_gain;
   logic [DATA_W-1:0]   cpad_ff [0:COS_PAD-1];

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff         <= MODE_LIN;
         lin_offset_ff   <= 16'sd4096;
         lin_slope_ff    <= 16'sd4096;
         pow_offset_ff   <= 16'sd4096;
         pow_slope_ff    <= 16'sd4096;
         pow_exponent_ff <= 16'd8192;
         cos_gain_ff     <= 16'sd4096;
         cos_width_ff    <= 16'd4096;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index_type'(csr_index))
            CSR_MODE:         mode_ff         <= mode_type'(csr_data[1:0]);
            CSR_LIN_OFFSET:   lin_offset_ff   <= csr_data;
            CSR_LIN_SLOPE:    lin_slope_ff    <= csr_data;
            CSR_POW_OFFSET:   pow_offset_ff   <= csr_data;
            CSR_POW_SLOPE:    pow_slope_ff    <= csr_data;
            CSR_POW_EXPONENT: pow_exponent_ff <= csr_data;
            CSR_COS_GAIN:     cos_gain_ff     <= csr_data;
            CSR_COS_WIDTH:    cos_width_ff    <= csr_data;
            default: ;
         endcase
      end
   end

   // advance everything unless the result item is held
   assign adv       = !vld_ff[CORE_LAT-1] || rsp_ready;
   assign req_ready = adv;
   assign rsp_valid = vld_ff[CORE_LAT-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[CORE_LAT-2:0], req_valid};
      end
   end

   assign sel_lin   = (mode_ff == MODE_LIN);
   assign aff_off   = sel_lin ? lin_offset_ff : pow_offset_ff;
   assign aff_slope = sel_lin ? lin_slope_ff  : pow_slope_ff;

   dgr_power u_power (
      .clock    (clock),
      .adv      (adv),
      .in_d     (req_distance),
      .exponent (pow_exponent_ff),
      .sel_lin  (sel_lin),
      .out_w    (pwr_w)
   );

   dgr_affine u_affine (
      .clock  (clock),
      .adv    (adv),
      .w      (pwr_w),
      .offset (aff_off),
      .slope  (aff_slope),
      .gain   (aff_gain)
   );

   dgr_cosine u_cosine (
      .clock  (clock),
      .adv    (adv),
      .in_d   (req_distance),
      .cgain  (cos_gain_ff),
      .cwidth (cos_width_ff),
      .gain   (cos_gain)
   );

   // delay cosine results to the depth of the power path
   always_ff @(posedge clock) begin
      if (adv) begin
         cpad_ff[0] <= cos_gain;
         for (int i = 1; i < COS_PAD; i++) begin
            cpad_ff[i] <= cpad_ff[i-1];
         end
      end
   end

   always_comb begin
      case (mode_ff) inside
         MODE_LIN, MODE_POW: rsp_gain = aff_gain;
         MODE_COS:           rsp_gain = cpad_ff[COS_PAD-1];
         default:            rsp_gain = '0;
      endcase
   end

   a_ready_low_only_on_stall: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid && !rsp_ready)
      else $error("input stalled without a held result item");

   a_item_enters: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> vld_ff[0])
      else $error("accepted item lost at pipeline entry");

   a_stall_freezes: assert property (@(posedge clock) disable iff (reset)
      !adv |=> $stable(vld_ff))
      else $error("pipeline moved while the result item was held");

   a_zero_mode: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && mode_ff == MODE_ZERO |-> rsp_gain == '0)
      else $error("zero mode gave a nonzero gain");

   a_cos_negative_peak: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && mode_ff == MODE_COS && cos_gain_ff[DATA_W-1] |-> rsp_gain == '0)
      else $error("negative cosine peak gave a nonzero gain");

endmodule

[tb/tb_distance_gain_rolloff_core.sv]
// ---------------------------------------------------------------------------
// tb_distance_gain_rolloff_core
// Self-checking bench for the distance gain roll-off core: directed corners
// and random distances under several curve settings, with random stalls.
// ---------------------------------------------------------------------------
module tb_distance_gain_rolloff_core;
   timeunit 1ns;
   timeprecision 1ps;
   import dgr_pkg::*;

   localparam int WATCHDOG_LIMIT = 20000;
   localparam int DRAIN_CYCLES   = 80;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_ready;
   logic [DATA_W-1:0]   req_distance = '0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   logic [DATA_W-1:0]   rsp_gain;
   logic                csr_valid = 1'b0;
   logic                csr_ready;
   logic [2:0]          csr_index = '0;
   logic [DATA_W-1:0]   csr_data = '0;

   // shadow copy of the registers
   mode_type            cfg_mode;
   logic [DATA_W-1:0]   cfg_lin_off, cfg_lin_slope, cfg_pow_off, cfg_pow_slope;
   logic [DATA_W-1:0]   cfg_pow_exp, cfg_cos_gain, cfg_cos_width;

   logic [DATA_W-1:0]   gain_queue[$];
   int                  error_count = 0;
   int                  sent_count = 0;
   int                  checked_count = 0;
   int                  idle_cycles = 0;
   int                  rx_wait = 0;
   bit                  rx_stall_off = 1'b0;

   distance_gain_rolloff_core DUT (.*);

   always #1 clock = ~clock;

   // ---------------- gain predictor ----------------
   localparam longint DMAX  = 64'hFFFF;
   localparam longint W_BIG = 64'sh4000_0000_0000_0000;

   function automatic longint sext16(logic [DATA_W-1:0] v);
      return longint'($signed(v));
   endfunction

   function automatic longint fl_shr(longint x, int s);
      return x >>> s;   // arithmetic shift floors
   endfunction

   function automatic logic [DATA_W-1:0] clamp_gain(longint y);
      if (y < 0) return '0;
      if (y > DMAX) return '1;
      return y[DATA_W-1:0];
   endfunction

   function automatic logic [63:0] floor_sqrt(logic [63:0] n);
      logic [63:0] res, bt;
      res = 0;
      bt = 64'd1 << 62;
      while (bt > n) bt = bt >> 2;
      while (bt != 0) begin
         if (n >= res + bt) begin
            n = n - (res + bt);
            res = (res >> 1) + bt;
         end else begin
            res = res >> 1;
         end
         bt = bt >> 2;
      end
      return res;
   endfunction

   function automatic logic [DATA_W-1:0] affine_gain(longint off, longint slope,
                                                       logic [63:0] w);
      logic [63:0] mag;
      longint num;
      if (w != 0 && slope != 0) begin
         mag = (slope < 0) ? -slope : slope;
         if (mag > 64'(W_BIG) / w) return (slope > 0) ? '0 : '1;
      end
      num = off * (64'sd1 <<< FRAC_W) - slope * longint'(w);
      return clamp_gain(fl_shr(num + (64'sd1 <<< (FRAC_W - 1)), FRAC_W));
   endfunction

   function automatic logic [63:0] dist_power(logic [63:0] d, logic [63:0] e);
      logic [63:0] m, frac, r, acc;
      longint lg, z, zi, zf, s;
      int p;
      if (e == 0) return 64'd1 << FRAC_W;
      if (d == 0) return 0;
      p = 31;
      frac = 0;
      while (d[p] == 1'b0) p--;
      m = d << (31 - p);
      for (int i = 0; i < LOG_W; i++) begin
         m = (m * m) >> 31;
         frac = frac << 1;
         if (m >= (64'd1 << 32)) begin
            frac = frac | 1;
            m = m >> 1;
         end
      end
      lg = (longint'(p) - FRAC_W) * (64'sd1 <<< LOG_W) + longint'(frac);
      z  = fl_shr(lg * longint'(e), FRAC_W);
      zi = fl_shr(z, LOG_W);
      zf = z - zi * (64'sd1 <<< LOG_W);
      r = 64'd1 << 31;
      acc = 64'd1 << 30;
      for (int k = 1; k <= LOG_W; k++) begin
         r = floor_sqrt(r << 30);
         if ((64'(zf) >> (LOG_W - k)) & 1) acc = (acc * r) >> 30;
      end
      s = zi + FRAC_W - 30;
      if (s > 31) return 64'(W_BIG);
      if (s >= 0) return acc << s;
      if (-s > 40) return 0;
      return (acc + (64'd1 << (-s - 1))) >> (-s);
   endfunction

   function automatic logic [DATA_W-1:0] cos_rolloff(logic [63:0] d);
      logic [63:0] w, u;
      longint v, t, c;
      w = cfg_cos_width;
      if (w == 0) w = 1;
      u = (d << 30) / w;
      if (u > (64'd1 << 30)) u = 64'd1 << 30;
      v = longint'((u * u) >> 30);
      t = 27061;
      t = 987048 - ((v * t) >>> 30);
      t = 22401991 - ((v * t) >>> 30);
      t = 272375560 - ((v * t) >>> 30);
      t = 1324675879 - ((v * t) >>> 30);
      c = (64'sd1 <<< 30) - ((v * t) >>> 30);
      if (c < 0) c = 0;
      return clamp_gain(fl_shr(sext16(cfg_cos_gain) * c + (64'sd1 <<< 29), 30));
   endfunction

   function automatic logic [DATA_W-1:0] predict_gain(logic [DATA_W-1:0] d_item);
      case (cfg_mode)
         MODE_LIN: return affine_gain(sext16(cfg_lin_off), sext16(cfg_lin_slope),
                                      64'(d_item));
         MODE_POW: return affine_gain(sext16(cfg_pow_off), sext16(cfg_pow_slope),
                                      dist_power(64'(d_item), 64'(cfg_pow_exp)));
         MODE_COS: return cos_rolloff(64'(d_item));
         default:  return '0;
      endcase
   endfunction

   // ---------------- driving ----------------
   task automatic wait_cycles(int n);
      repeat (n) @(posedge clock);
   endtask

   task automatic send_distance(logic [DATA_W-1:0] d_item, bit gaps);
      int n;
      n = gaps ? $urandom_range(0, 16) : 0;
      if (n > 0) begin
         req_valid <= 1'b0;
         wait_cycles(n);
      end
      req_valid <= 1'b1;
      req_distance <= d_item;
      gain_queue = {gain_queue, predict_gain(d_item)};
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sent_count++;
   endtask

   task automatic drain_pipeline();
      req_valid <= 1'b0;
      while (gain_queue.size() != 0) @(posedge clock);
      wait_cycles(DRAIN_CYCLES);
   endtask

   task automatic write_reg(csr_index_type idx, logic [DATA_W-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      case (idx)
         CSR_MODE:         cfg_mode = mode_type'(val[1:0]);
         CSR_LIN_OFFSET:   cfg_lin_off = val;
         CSR_LIN_SLOPE:    cfg_lin_slope = val;
         CSR_POW_OFFSET:   cfg_pow_off = val;
         CSR_POW_SLOPE:    cfg_pow_slope = val;
         CSR_POW_EXPONENT: cfg_pow_exp = val;
         CSR_COS_GAIN:     cfg_cos_gain = val;
         default:          cfg_cos_width = val;
      endcase
      @(posedge clock);
   endtask

   task automatic random_distances(int n);
      logic [DATA_W-1:0] d_item;
      for (int i = 0; i < n; i++) begin
         case ($urandom_range(0, 3))
            0:       d_item = 16'($urandom_range(0, 16'h2000));
            1:       d_item = 16'($urandom_range(0, 64));
            default: d_item = 16'($urandom);
         endcase
         send_distance(d_item, ($urandom_range(0, 3) != 0));
      end
   endtask

   // ---------------- tests ----------------
   task automatic test_reset_defaults();
      logic [DATA_W-1:0] corners[6] = '{16'h0000, 16'h0001, 16'h0800, 16'h1000,
                                        16'h8000, 16'hFFFF};
      cfg_mode = MODE_LIN;
      cfg_lin_off = 16'h1000;  cfg_lin_slope = 16'h1000;
      cfg_pow_off = 16'h1000;  cfg_pow_slope = 16'h1000;
      cfg_pow_exp = 16'h2000;  cfg_cos_gain = 16'h1000;
      cfg_cos_width = 16'h1000;
      foreach (corners[i]) send_distance(corners[i], 1'b0);
      drain_pipeline();
   endtask

   task automatic test_every_mode();
      logic [DATA_W-1:0] corners[4] = '{16'h0000, 16'h0800, 16'h1000, 16'hFFFF};
      for (int m = 0; m < 4; m++) begin
         write_reg(CSR_MODE, 16'(m));
         foreach (corners[i]) send_distance(corners[i], 1'b0);
         drain_pipeline();
      end
   endtask

   task automatic test_special_cases();
      // zero exponent gives 0^0 = 1, zero width counts as one LSB
      write_reg(CSR_MODE, 16'(MODE_POW));
      write_reg(CSR_POW_EXPONENT, 16'h0000);
      send_distance(16'h0000, 1'b0);
      send_distance(16'h3000, 1'b0);
      drain_pipeline();
      write_reg(CSR_POW_EXPONENT, 16'hFFFF);
      write_reg(CSR_POW_SLOPE, 16'h8000);
      send_distance(16'hFFFF, 1'b0);
      send_distance(16'h0001, 1'b0);
      drain_pipeline();
      write_reg(CSR_MODE, 16'(MODE_COS));
      write_reg(CSR_COS_WIDTH, 16'h0000);
      write_reg(CSR_COS_GAIN, 16'h7FFF);
      send_distance(16'h0000, 1'b0);
      send_distance(16'h0001, 1'b0);
      drain_pipeline();
   endtask

   task automatic test_random_settings(int phases, int per_phase);
      logic [DATA_W-1:0] extremes[5] = '{16'h0000, 16'h0001, 16'h7FFF,
                                         16'h8000, 16'hFFFF};
      for (int ph = 0; ph < phases; ph++) begin
         write_reg(CSR_MODE, 16'($urandom_range(0, 3)));
         for (int r = 1; r <= 7; r++) begin
            if ($urandom_range(0, 2) == 0)
               write_reg(csr_index_type'(r), extremes[$urandom_range(0, 4)]);
            else if (csr_index_type'(r) == CSR_POW_EXPONENT)
               write_reg(csr_index_type'(r), 16'($urandom_range(0, 16'h4000)));
            else
               write_reg(csr_index_type'(r), 16'($urandom));
         end
         rx_stall_off = (ph % 4 == 3);
         random_distances(per_phase);
         drain_pipeline();
      end
      rx_stall_off = 1'b0;
   endtask

   // ---------------- result checking ----------------
   initial begin : rsp_side
      logic [DATA_W-1:0] want;
      forever begin
         @(posedge clock);
         if (rsp_valid && rsp_ready) begin
            if (gain_queue.size() == 0) begin
               $error("unexpected item: gain %0h", rsp_gain);
               error_count++;
            end else begin
               want = gain_queue.pop_front();
               checked_count++;
               if (rsp_gain !== want) begin
                  $error("gain: expected %0h actual %0h", want, rsp_gain);
                  error_count++;
               end
            end
            rx_wait = $urandom_range(0, 16);
         end else if (rsp_valid && rx_wait > 0) begin
            rx_wait--;
         end
         rsp_ready <= rx_stall_off || (rx_wait == 0);
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready) || gain_queue.size() == 0)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("timeout with %0d items outstanding", gain_queue.size());
         $display("FAIL distance_gain_rolloff_core");
         $finish;
      end
   end

   initial begin
      wait_cycles(12);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_defaults();
      test_every_mode();
      test_special_cases();
      // push random distances with random gaps, then hold the sender until all gains have arrived
      write_reg(CSR_MODE, 16'(MODE_LIN));
      random_distances(30);
      drain_pipeline();
      test_random_settings(24, 50);
      drain_pipeline();
      $display("sent %0d distances, checked %0d gains over all curve modes", sent_count,
               checked_count);
      $display("register extremes, zero width, zero exponent and stalls exercised");
      if (error_count == 0 && gain_queue.size() == 0)
         $display("PASS distance_gain_rolloff_core");
      else
         $display("FAIL distance_gain_rolloff_core");
      $finish;
   end

endmodule

[files.f]
design/dgr_pkg.sv
design/dgr_power.sv
design/dgr_affine.sv
design/dgr_cosine.sv
design/distance_gain_rolloff_core.sv
tb/tb_distance_gain_rolloff_core.sv
